FILE: hw/rtl/r2q_pkg.sv
`default_nettype none

package r2q_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned ELEM_W        = 16;
  localparam int unsigned MAG_W         = 17;
  localparam int unsigned Q_W           = 17;

  typedef enum logic [1:0] {
    BR_TRACE,
    BR_X,
    BR_Y,
    BR_Z
  } branch_e;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_00;
    logic signed [ELEM_W-1:0] elem_01;
    logic signed [ELEM_W-1:0] elem_02;
    logic signed [ELEM_W-1:0] elem_10;
    logic signed [ELEM_W-1:0] elem_11;
    logic signed [ELEM_W-1:0] elem_12;
    logic signed [ELEM_W-1:0] elem_20;
    logic signed [ELEM_W-1:0] elem_21;
    logic signed [ELEM_W-1:0] elem_22;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] quat_w;
    logic signed [ELEM_W-1:0] quat_x;
    logic signed [ELEM_W-1:0] quat_y;
    logic signed [ELEM_W-1:0] quat_z;
  } out_t;

  // branch and the three signed numerators as sign and magnitude
  typedef struct packed {
    branch_e                     br;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
  } side_t;

  function automatic logic signed [ELEM_W-1:0] sat16(input logic signed [31:0] v);
    logic signed [ELEM_W-1:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[ELEM_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/r2q_sqrt.sv
`default_nettype none

module r2q_sqrt #(
  parameter int unsigned N_W = 30
) (
  input  wire logic               clk_i,
  input  wire logic [N_W/2-1:0]   en_i,
  input  wire logic [N_W-1:0]     n_i,
  output      logic [N_W/2-1:0]   root_o
);

  localparam int unsigned RT_W  = N_W / 2;
  localparam int unsigned REM_W = RT_W + 1;
  localparam int unsigned CW    = RT_W + 3;

  logic [REM_W-1:0] rem_q  [RT_W];
  logic [RT_W-1:0]  root_q [RT_W];
  logic [N_W-1:0]   nr_q   [RT_W];

  for (genvar s = 0; s < RT_W; s++) begin : g_stage
    logic [REM_W-1:0] rem_p, rem_d;
    logic [RT_W-1:0]  root_p, root_d;
    logic [N_W-1:0]   nr_p, nr_d;
    logic [CW-1:0]    cur, trial;

    if (s == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign nr_p   = n_i;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign nr_p   = nr_q[s-1];
    end

    always_comb begin
      cur   = {rem_p, nr_p[N_W-1 -: 2]};
      trial = CW'({root_p, 2'b01});
      nr_d  = nr_p << 2;
      if (cur >= trial) begin
        rem_d  = REM_W'(cur - trial);
        root_d = {root_p[RT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(cur);
        root_d = {root_p[RT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        nr_q[s]   <= nr_d;
      end
    end
  end

  assign root_o = root_q[RT_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/r2q_div.sv
`default_nettype none

module r2q_div #(
  parameter int unsigned NUM_W = 33,
  parameter int unsigned DEN_W = 18,
  parameter int unsigned Q_W   = 17
) (
  input  wire logic             clk_i,
  input  wire logic [Q_W-1:0]   en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output      logic [Q_W-1:0]   q_o
);

  logic [NUM_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   q_q   [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int unsigned BIT = Q_W - 1 - s;
    logic [NUM_W-1:0] rem_p, rem_d;
    logic [DEN_W-1:0] den_p;
    logic [Q_W-1:0]   q_p, q_d;

    if (s == 0) begin : g_first
      assign rem_p = num_i;
      assign den_p = den_i;
      assign q_p   = '0;
    end else begin : g_next
      assign rem_p = rem_q[s-1];
      assign den_p = den_q[s-1];
      assign q_p   = q_q[s-1];
    end

    always_comb begin
      if ((rem_p >> BIT) >= NUM_W'(den_p)) begin
        rem_d = rem_p - (NUM_W'(den_p) << BIT);
        q_d   = q_p | (Q_W'(1) << BIT);
      end else begin
        rem_d = rem_p;
        q_d   = q_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_p;
        q_q[s]   <= q_d;
      end
    end
  end

  assign q_o = q_q[Q_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/rotation_matrix_to_quaternion.sv
// Converts a 3x3 rotation matrix (nine signed fixed-point elements with FRAC_BITS fraction
// bits) into the quaternion w, x, y, z, each saturated to 16 bits. A new matrix is taken every
// cycle while the input is ready, and one quaternion leaves per matrix, in order. The stages
// are one front stage for branch choice and radicand, one stage per square-root bit, one
// stage per quotient bit in three parallel divider lanes, and the output register. A stalled
// output fills the empty stages first; the input stalls only once every stage holds a
// request.
`default_nettype none

module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = r2q_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire r2q_pkg::in_t  in_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      r2q_pkg::out_t out_o
);

  localparam int unsigned ELEM_W = r2q_pkg::ELEM_W;
  localparam int unsigned MAG_W  = r2q_pkg::MAG_W;
  localparam int unsigned Q_W    = r2q_pkg::Q_W;
  localparam int unsigned RAD_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int unsigned RS_W   = RAD_W + 1;
  localparam int unsigned NW     = RAD_W + FRAC_BITS - 2;
  localparam int unsigned SQ_W   = NW + (NW % 2);
  localparam int unsigned RT_W   = SQ_W / 2;
  localparam int unsigned NUM_W  = FRAC_BITS + 19;
  localparam int unsigned DEN_W  = RT_W + 3;
  localparam int unsigned DW     = MAG_W + 1;
  localparam int unsigned NS     = RT_W + Q_W + 2;
  localparam logic signed [RS_W-1:0] ONE = RS_W'(1) <<< FRAC_BITS;

  logic [NS-1:0] v_q, en, v_in;

  assign v_in = {v_q[NS-2:0], in_valid_i};

  // a stage loads when some stage at or after it is empty or the output drains
  for (genvar k = 0; k < NS; k++) begin : g_ctl
    assign en[k] = out_ready_i | ~(&v_q[NS-1:k]);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in[k];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // front stage: branch choice, radicand, numerators
  logic signed [RS_W-1:0] e00, e11, e22, tr, sel, rad;
  logic signed [DW-1:0]   d [3];
  r2q_pkg::side_t         fr_side_d, fr_side_q;
  logic [SQ_W-1:0]        fr_n_d, fr_n_q;

  always_comb begin
    e00 = RS_W'(in_i.elem_00);
    e11 = RS_W'(in_i.elem_11);
    e22 = RS_W'(in_i.elem_22);
    tr  = e00 + e11 + e22;
    if (!tr[RS_W-1] && (tr != '0)) begin
      fr_side_d.br = r2q_pkg::BR_TRACE;
      sel  = tr;
      d[0] = DW'(in_i.elem_21) - DW'(in_i.elem_12);
      d[1] = DW'(in_i.elem_02) - DW'(in_i.elem_20);
      d[2] = DW'(in_i.elem_10) - DW'(in_i.elem_01);
    end else if ((in_i.elem_00 > in_i.elem_11) && (in_i.elem_00 > in_i.elem_22)) begin
      fr_side_d.br = r2q_pkg::BR_X;
      sel  = e00 - e11 - e22;
      d[0] = DW'(in_i.elem_01) + DW'(in_i.elem_10);
      d[1] = DW'(in_i.elem_20) + DW'(in_i.elem_02);
      d[2] = DW'(in_i.elem_21) - DW'(in_i.elem_12);
    end else if (in_i.elem_11 > in_i.elem_22) begin
      fr_side_d.br = r2q_pkg::BR_Y;
      sel  = e11 - e00 - e22;
      d[0] = DW'(in_i.elem_01) + DW'(in_i.elem_10);
      d[1] = DW'(in_i.elem_12) + DW'(in_i.elem_21);
      d[2] = DW'(in_i.elem_02) - DW'(in_i.elem_20);
    end else begin
      fr_side_d.br = r2q_pkg::BR_Z;
      sel  = e22 - e00 - e11;
      d[0] = DW'(in_i.elem_02) + DW'(in_i.elem_20);
      d[1] = DW'(in_i.elem_12) + DW'(in_i.elem_21);
      d[2] = DW'(in_i.elem_10) - DW'(in_i.elem_01);
    end
    rad = ONE + sel;
    if (rad < ONE) begin
      rad = ONE;
    end
    fr_n_d = SQ_W'(rad[RAD_W-1:0]) << (FRAC_BITS - 2);
    for (int i = 0; i < 3; i++) begin
      fr_side_d.neg[i] = d[i][DW-1];
      fr_side_d.mag[i] = d[i][DW-1] ? MAG_W'(-d[i]) : MAG_W'(d[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      fr_side_q <= fr_side_d;
      fr_n_q    <= fr_n_d;
    end
  end

  // square root
  logic [RT_W-1:0] root;

  r2q_sqrt #(
    .N_W (SQ_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en[RT_W:1]),
    .n_i    (fr_n_q),
    .root_o (root)
  );

  r2q_pkg::side_t side_sq_q [RT_W];

  for (genvar j = 0; j < RT_W; j++) begin : g_sq_side
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[1+j]) begin
          side_sq_q[j] <= fr_side_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[1+j]) begin
          side_sq_q[j] <= side_sq_q[j-1];
        end
      end
    end
  end

  // three divider lanes sharing the root
  logic [Q_W-1:0]   q [3];
  logic [NUM_W-1:0] num [3];
  logic [DEN_W-1:0] den;

  assign den = DEN_W'(root) << 3;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign num[i] = (NUM_W'(side_sq_q[RT_W-1].mag[i]) << (FRAC_BITS + 1))
                  + (NUM_W'(root) << 2);

    r2q_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .Q_W   (Q_W)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en[RT_W+Q_W:RT_W+1]),
      .num_i (num[i]),
      .den_i (den),
      .q_o   (q[i])
    );
  end

  r2q_pkg::side_t  side_dv_q [Q_W];
  logic [RT_W-1:0] b_dv_q    [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_dv_side
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[RT_W+1+j]) begin
          side_dv_q[j] <= side_sq_q[RT_W-1];
          b_dv_q[j]    <= root;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[RT_W+1+j]) begin
          side_dv_q[j] <= side_dv_q[j-1];
          b_dv_q[j]    <= b_dv_q[j-1];
        end
      end
    end
  end

  // sign, saturation and placement by branch
  logic signed [ELEM_W-1:0] big, s [3];
  r2q_pkg::out_t            out_d, out_q;

  always_comb begin
    big = r2q_pkg::sat16(32'(b_dv_q[Q_W-1]));
    for (int i = 0; i < 3; i++) begin
      s[i] = r2q_pkg::sat16(side_dv_q[Q_W-1].neg[i] ? -$signed(32'(q[i]))
                                                    : $signed(32'(q[i])));
    end
    case (side_dv_q[Q_W-1].br)
      r2q_pkg::BR_TRACE: out_d = '{quat_w: big,  quat_x: s[0], quat_y: s[1], quat_z: s[2]};
      r2q_pkg::BR_X:     out_d = '{quat_w: s[2], quat_x: big,  quat_y: s[0], quat_z: s[1]};
      r2q_pkg::BR_Y:     out_d = '{quat_w: s[2], quat_x: s[0], quat_y: big,  quat_z: s[1]};
      default:           out_d = '{quat_w: s[2], quat_x: s[0], quat_y: s[1], quat_z: big};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

  a_root_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[RT_W] |-> (root >= (RT_W'(1) << (FRAC_BITS - 1))))
    else $error("root below half scale");

  a_quot_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-2] |-> ((q[0] <= 17'd32768) && (q[1] <= 17'd32768) && (q[2] <= 17'd32768)))
    else $error("quotient out of range");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted request lost at front stage");

endmodule

`default_nettype wire

FILE: tb/rotation_matrix_to_quaternion_tb.sv
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion_tb;

  localparam int FRAC = r2q_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  r2q_pkg::in_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  r2q_pkg::out_t out_o;

  r2q_pkg::out_t quat_q[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit rx_random = 1'b1;

  always #2 clk_i = ~clk_i;

  rotation_matrix_to_quaternion u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint scaled_quot(longint d, longint unsigned b);
    longint unsigned mag, num, den, q;
    mag = (d < 0) ? -d : d;
    num = mag << FRAC;
    den = b * 4;
    q = (2 * num + den) / (2 * den);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic r2q_pkg::out_t matrix_to_quat(r2q_pkg::in_t m);
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22, one, tr, rad;
    longint d0, d1, d2, big, s0, s1, s2, w, x, y, z;
    longint unsigned b;
    r2q_pkg::branch_e br;
    r2q_pkg::out_t r;
    m00 = m.elem_00; m01 = m.elem_01; m02 = m.elem_02;
    m10 = m.elem_10; m11 = m.elem_11; m12 = m.elem_12;
    m20 = m.elem_20; m21 = m.elem_21; m22 = m.elem_22;
    one = 64'sd1 << FRAC;
    tr = m00 + m11 + m22;
    if (tr > 0) begin
      br = r2q_pkg::BR_TRACE; rad = one + tr;
      d0 = m21 - m12; d1 = m02 - m20; d2 = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      br = r2q_pkg::BR_X; rad = one + m00 - m11 - m22;
      d0 = m01 + m10; d1 = m20 + m02; d2 = m21 - m12;
    end else if (m11 > m22) begin
      br = r2q_pkg::BR_Y; rad = one + m11 - m00 - m22;
      d0 = m01 + m10; d1 = m12 + m21; d2 = m02 - m20;
    end else begin
      br = r2q_pkg::BR_Z; rad = one + m22 - m00 - m11;
      d0 = m02 + m20; d1 = m12 + m21; d2 = m10 - m01;
    end
    if (rad < one) rad = one;
    b = int_sqrt(longint'(rad) << (FRAC - 2));
    if (b == 0) b = 1;
    big = b;
    s0 = scaled_quot(d0, b);
    s1 = scaled_quot(d1, b);
    s2 = scaled_quot(d2, b);
    case (br)
      r2q_pkg::BR_TRACE: begin w = big; x = s0; y = s1; z = s2; end
      r2q_pkg::BR_X:     begin x = big; y = s0; z = s1; w = s2; end
      r2q_pkg::BR_Y:     begin y = big; x = s0; z = s1; w = s2; end
      default:           begin z = big; x = s0; y = s1; w = s2; end
    endcase
    r.quat_w = clip16(w);
    r.quat_x = clip16(x);
    r.quat_y = clip16(y);
    r.quat_z = clip16(z);
    return r;
  endfunction

  // valid stays high into the next request when there is no gap
  task automatic send_matrix(r2q_pkg::in_t m, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= m;
    quat_q.push_back(matrix_to_quat(m));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // back-to-back sends keep valid high without dropping it
  task automatic send_burst(r2q_pkg::in_t m);
    in_valid_i <= 1'b1;
    in_i <= m;
    quat_q.push_back(matrix_to_quat(m));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic r2q_pkg::in_t rand_matrix();
    r2q_pkg::in_t m;
    m = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    return m;
  endfunction

  function automatic logic signed [15:0] near(int base);
    return 16'(base + int'($urandom_range(0, 200)) - 100);
  endfunction

  // near-rotation from a random signed permutation, perturbed
  function automatic r2q_pkg::in_t rand_rotation();
    logic signed [15:0] e[9];
    int p, s, r, c;
    r2q_pkg::in_t m;
    p = $urandom_range(0, 5);
    for (int i = 0; i < 9; i++) e[i] = near(0);
    for (r = 0; r < 3; r++) begin
      c = (p < 3) ? (r + p) % 3 : (p - r) % 3;
      s = $urandom_range(0, 1) ? 16384 : -16384;
      e[r * 3 + c] = near(s);
    end
    if ($urandom_range(0, 2) == 0)
      for (int i = 0; i < 9; i++) e[i] = 16'($signed(e[i]) / 2 + near(0));
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  function automatic r2q_pkg::in_t diag(int a, int b, int c, int off);
    r2q_pkg::in_t m;
    m = '{default: 16'(off)};
    m.elem_00 = 16'(a); m.elem_11 = 16'(b); m.elem_22 = 16'(c);
    return m;
  endfunction

  task automatic test_branches();
    send_matrix(diag(16384, 16384, 16384, 0), 1'b0);
    send_matrix(diag(16384, -16384, -16384, 0), 1'b0);
    send_matrix(diag(-16384, 16384, -16384, 0), 1'b0);
    send_matrix(diag(-16384, -16384, 16384, 0), 1'b0);
    send_matrix(diag(0, 0, 0, 1000), 1'b0);
    send_matrix(diag(-100, -100, -100, -700), 1'b0);
    send_matrix(diag(-5000, -5000, 0, 3000), 1'b0);
    send_matrix(diag(0, -5000, -5000, 3000), 1'b0);
    send_matrix(diag(-5000, 0, -5000, 3000), 1'b0);
    send_matrix(diag(-3000, -3000, -3000, -2000), 1'b0);
    send_matrix(diag(1, 0, -1, 0), 1'b0);
    drop_valid();
  endtask

  task automatic test_extremes();
    send_matrix('{default: 16'sh7fff}, 1'b0);
    send_matrix('{default: 16'sh8000}, 1'b0);
    send_matrix('0, 1'b0);
    send_matrix(diag(-32768, -32768, -32768, 32767), 1'b0);
    send_matrix(diag(-32768, -32768, -32768, -32768), 1'b0);
    send_matrix(diag(32767, -32768, -32768, 32767), 1'b0);
    send_matrix(diag(-32768, 32767, -32768, -32768), 1'b0);
    send_matrix(diag(-32768, -32768, 32767, 32767), 1'b0);
    send_matrix(diag(32767, 32767, 32767, -32768), 1'b0);
    send_matrix('{default: 16'shffff}, 1'b0);
    drop_valid();
  endtask

  task automatic test_random();
    for (int i = 0; i < 900; i++)
      send_matrix(($urandom_range(0, 3) == 0) ? rand_matrix() : rand_rotation(), 1'b1);
    drop_valid();
  endtask

  task automatic test_backpressure();
    wait (quat_q.size() == 0);
    rx_random = 1'b0;
    hold_off = 1'b1;
    for (int i = 0; i < 80; i++) send_burst(rand_rotation());
    in_valid_i <= 1'b0;
    rx_random = 1'b1;
    @(posedge clk_i);
  endtask

  // long hold-off counted in its own process
  initial begin
    wait (hold_off);
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (!rx_random) begin
        out_ready_i <= 1'b1;
      end else if (out_ready_i && out_valid_o) begin
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    r2q_pkg::out_t exp_q;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quat_q.size() == 0) begin
        $error("unexpected request result %h", out_o);
        errors++;
      end else begin
        exp_q = quat_q.pop_front();
        if (out_o.quat_w !== exp_q.quat_w) begin
          $error("quat_w exp %0d got %0d", exp_q.quat_w, out_o.quat_w); errors++;
        end
        if (out_o.quat_x !== exp_q.quat_x) begin
          $error("quat_x exp %0d got %0d", exp_q.quat_x, out_o.quat_x); errors++;
        end
        if (out_o.quat_y !== exp_q.quat_y) begin
          $error("quat_y exp %0d got %0d", exp_q.quat_y, out_o.quat_y); errors++;
        end
        if (out_o.quat_z !== exp_q.quat_z) begin
          $error("quat_z exp %0d got %0d", exp_q.quat_z, out_o.quat_z); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rotation_matrix_to_quaternion_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_branches();
    test_extremes();
    test_backpressure();
    test_random();
    wait (quat_q.size() == 0);
    repeat (LATENCY) @(posedge clk_i);
    if (errors == 0 && quat_q.size() == 0) begin
      $display("rotation_matrix_to_quaternion_tb: PASS");
    end else begin
      $display("rotation_matrix_to_quaternion_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
